// ===== sv/assert_macros.svh =====
// Assertion macros used by the top level of the circular list block.
// Each macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/clc_pkg.sv =====
// Shared types and codes for the circular list with cursor.
// No dependencies; used by clc_free_stack and the top level.
package clc_pkg;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_NEXT   = 2'd1;
  localparam logic [1:0] OP_START  = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // Width used to sign-extend stored words before cutting them to port width.
  localparam int WIDE_W = 64;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] cursor_value;
    logic signed [31:0] removed_value;
    logic [6:0]         list_length;
  } out_item_t;

  // Commands from the sequencer to the free stack.
  typedef struct packed {
    logic rd;
    logic pop;
    logic push;
  } fs_cmd_t;

endpackage

// ===== sv/clc_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies.
module clc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/clc_free_stack.sv =====
// Free-index stack of the node store, kept in a RAM with a low-water mark.
// Depends on clc_pkg (command struct) and clc_ram.
module clc_free_stack #(
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     rst,
  input  clc_pkg::fs_cmd_t         cmd,
  input  logic [$clog2(DEPTH)-1:0] push_index,
  output logic [$clog2(DEPTH)-1:0] alloc_index
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Stack slots below the low-water mark were never overwritten since reset, so
  // slot p still holds its reset content DEPTH-1-p and need not be read from RAM.
  logic [CW-1:0] fcount;
  logic [CW-1:0] low;
  logic [CW-1:0] fcount_dec;
  logic [CW-1:0] fresh_calc;
  logic          fresh_q;
  logic [AW-1:0] fresh_idx_q;
  logic          push_ok;
  logic [AW-1:0] ram_q;

  assign fcount_dec = fcount - CW'(1);
  assign fresh_calc = CW'(DEPTH) - fcount;
  assign push_ok    = cmd.push && (fcount < CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      fcount <= CW'(DEPTH);
      low    <= CW'(DEPTH);
    end else if (cmd.pop) begin
      fcount <= fcount_dec;
      if (fcount_dec < low) begin
        low <= fcount_dec;
      end
    end else if (push_ok) begin
      fcount <= fcount + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      fresh_q     <= (fcount <= low);
      fresh_idx_q <= fresh_calc[AW-1:0];
    end
  end

  clc_ram #(
    .WIDTH(AW),
    .DEPTH(DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .we   (push_ok),
    .waddr(fcount[AW-1:0]),
    .wdata(push_index),
    .re   (cmd.rd),
    .raddr(fcount_dec[AW-1:0]),
    .rdata(ram_q)
  );

  assign alloc_index = fresh_q ? fresh_idx_q : ram_q;

endmodule

// ===== sv/circular_list_with_cursor_top.sv =====
// Top level of the bounded circular singly linked list with cursor.
// Depends on clc_pkg, clc_ram, clc_free_stack and assert_macros.svh.

// A bounded ring of up to DEPTH signed words with a cursor. Each input item carries
// an operation (add at tail, advance cursor, cursor to head, remove at cursor) and a
// value used only by add; each item yields exactly one result item with the status
// (ok, empty, full), the word under the cursor after the step (0 when the list is
// empty), the word removed (0 unless a remove succeeded) and the new length. The node
// words and links live in two synchronous RAMs, and free node indices on a RAM-backed
// stack that needs no clearing pass after reset. An item is worked on in order: first
// the cursor node and the top of the free stack are read, then the pointers are
// updated and the RAMs written, and last the new cursor word is collected and the
// result register loaded, as the node RAMs have registered read data. The next item
// is taken once the result is loaded, even while that result waits to be taken; a stalled
// result holds the block in its final state until the output register frees up.
`include "assert_macros.svh"

module circular_list_with_cursor_top #(
  parameter int DEPTH      = 64,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  clc_pkg::in_item_t    item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output clc_pkg::out_item_t   result
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;

  // List pointers and counts.
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [AW-1:0] cur, cur_next;
  logic [AW-1:0] bcur, bcur_next;
  logic [CW-1:0] count, count_next;

  // Item held while it is being worked on.
  logic [1:0]                   op_q;
  logic signed [DATA_WIDTH-1:0] val_q;
  logic [1:0]                   status_q, status_next;
  logic signed [DATA_WIDTH-1:0] removed_q, removed_next;
  logic                         fwd_q;

  // Second link write of an add to a non-empty list, done in the final state.
  logic          link2_pend;
  logic [AW-1:0] link2_addr;
  logic [AW-1:0] link2_data;

  // RAM ports.
  logic                         data_we;
  logic [AW-1:0]                data_waddr;
  logic                         data_re;
  logic [AW-1:0]                data_raddr;
  logic signed [DATA_WIDTH-1:0] data_rd;
  logic                         link_we;
  logic [AW-1:0]                link_waddr;
  logic [AW-1:0]                link_wdata;
  logic [AW-1:0]                link_rd;

  clc_pkg::fs_cmd_t fs_cmd;
  logic [AW-1:0]    alloc_index;

  logic accept;
  logic add_ok;
  logic result_load;

  logic signed [clc_pkg::WIDE_W-1:0] value_wide;
  logic signed [DATA_WIDTH-1:0]      cur_word;
  logic signed [clc_pkg::WIDE_W-1:0] cur_wide;
  logic signed [clc_pkg::WIDE_W-1:0] rem_wide;

  assign item_ready  = (state == S_IDLE);
  assign accept      = item_valid && item_ready;
  assign result_load = (state == S_DONE) && (!result_valid || result_ready);

  // The input word is sign-extended and then cut to the stored width.
  assign value_wide = clc_pkg::WIDE_W'(item.value);

  // Node RAMs. The cursor node is read when an item arrives; the data RAM is read
  // again at the new cursor while the update is written.
  assign data_re    = accept || (state == S_EXEC);
  assign data_raddr = (state == S_EXEC) ? cur_next : cur;

  clc_ram #(
    .WIDTH(DATA_WIDTH),
    .DEPTH(DEPTH)
  ) u_data_ram (
    .clk  (clk),
    .we   (data_we),
    .waddr(data_waddr),
    .wdata(val_q),
    .re   (data_re),
    .raddr(data_raddr),
    .rdata(data_rd)
  );

  clc_ram #(
    .WIDTH(AW),
    .DEPTH(DEPTH)
  ) u_link_ram (
    .clk  (clk),
    .we   (link_we),
    .waddr(link_waddr),
    .wdata(link_wdata),
    .re   (accept),
    .raddr(cur),
    .rdata(link_rd)
  );

  clc_free_stack #(
    .DEPTH(DEPTH)
  ) u_free_stack (
    .clk        (clk),
    .rst        (rst),
    .cmd        (fs_cmd),
    .push_index (cur),
    .alloc_index(alloc_index)
  );

  // Pointer update in the update cycle, with the cursor node's link and word and the
  // free-stack top already read out; also the stack read and the pending link write.
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    cur_next     = cur;
    bcur_next    = bcur;
    count_next   = count;
    status_next  = clc_pkg::ST_OK;
    removed_next = '0;
    add_ok       = 1'b0;
    data_we      = 1'b0;
    data_waddr   = alloc_index;
    link_we      = 1'b0;
    link_waddr   = '0;
    link_wdata   = '0;
    fs_cmd.rd    = accept;
    fs_cmd.pop   = 1'b0;
    fs_cmd.push  = 1'b0;

    if (state == S_EXEC) begin
      case (op_q)
        clc_pkg::OP_ADD: begin
          if (count == CW'(DEPTH)) begin
            status_next = clc_pkg::ST_FULL;
          end else begin
            add_ok     = 1'b1;
            data_we    = 1'b1;
            fs_cmd.pop = 1'b1;
            link_we    = 1'b1;
            link_waddr = alloc_index;
            if (count == '0) begin
              // The first node links to itself.
              link_wdata = alloc_index;
              head_next  = alloc_index;
              bcur_next  = alloc_index;
            end else begin
              link_wdata = head;
              bcur_next  = tail;
            end
            tail_next  = alloc_index;
            cur_next   = alloc_index;
            count_next = count + CW'(1);
          end
        end
        default: begin
          if (count == '0) begin
            status_next = clc_pkg::ST_EMPTY;
          end else begin
            case (op_q)
              clc_pkg::OP_NEXT: begin
                bcur_next = cur;
                cur_next  = link_rd;
              end
              clc_pkg::OP_START: begin
                cur_next  = head;
                bcur_next = tail;
              end
              clc_pkg::OP_REMOVE: begin
                removed_next = data_rd;
                fs_cmd.push  = 1'b1;
                count_next   = count - CW'(1);
                if (count == CW'(1)) begin
                  head_next = '0;
                  tail_next = '0;
                  cur_next  = '0;
                  bcur_next = '0;
                end else if (cur == head) begin
                  head_next  = link_rd;
                  link_we    = 1'b1;
                  link_waddr = tail;
                  link_wdata = link_rd;
                  cur_next   = link_rd;
                  bcur_next  = tail;
                end else if (cur == tail) begin
                  // The cursor wraps to the head.
                  tail_next  = bcur;
                  link_we    = 1'b1;
                  link_waddr = bcur;
                  link_wdata = head;
                  cur_next   = head;
                end else begin
                  link_we    = 1'b1;
                  link_waddr = bcur;
                  link_wdata = link_rd;
                  cur_next   = link_rd;
                end
              end
              default: begin
              end
            endcase
          end
        end
      endcase
    end else if ((state == S_DONE) && link2_pend) begin
      // Old tail now points at the node just added.
      link_we    = 1'b1;
      link_waddr = link2_addr;
      link_wdata = link2_data;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (result_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      head       <= '0;
      tail       <= '0;
      cur        <= '0;
      bcur       <= '0;
      count      <= '0;
      link2_pend <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      cur   <= cur_next;
      bcur  <= bcur_next;
      count <= count_next;
      if (state == S_EXEC) begin
        link2_pend <= add_ok && (count != '0);
      end else if (result_load) begin
        link2_pend <= 1'b0;
      end
    end
  end

  // Item payload and per-item results; no reset needed.
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= item.operation;
      val_q <= value_wide[DATA_WIDTH-1:0];
    end
    if (state == S_EXEC) begin
      status_q   <= status_next;
      removed_q  <= removed_next;
      fwd_q      <= add_ok;
      link2_addr <= tail;
      link2_data <= alloc_index;
    end
  end

  // The new node's word is written in the same cycle it is read back, so an add
  // forwards the stored word instead of the RAM output.
  assign cur_word = fwd_q ? val_q : data_rd;
  assign cur_wide = clc_pkg::WIDE_W'(cur_word);
  assign rem_wide = clc_pkg::WIDE_W'(removed_q);

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (result_load) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result_load) begin
      result.status        <= status_q;
      result.cursor_value  <= (count == '0) ? 32'sd0 : cur_wide[31:0];
      result.removed_value <= rem_wide[31:0];
      result.list_length   <= 7'(count);
    end
  end

  // Only one item is in the block at a time.
  `ASSERT_NEXT(a_one_item, item_valid && item_ready, !item_ready, "item taken while busy")
  // An empty list always has every pointer at its reset value.
  `ASSERT_IMPLY(a_empty_ptrs, count == '0, head == '0 && tail == '0 && cur == '0 && bcur == '0, "empty list with stray pointers")
  // A full status is reported only when every node is in use.
  `ASSERT_IMPLY(a_full_status, state == S_DONE && status_q == clc_pkg::ST_FULL, count == CW'(DEPTH), "full status below capacity")

endmodule
